### hw/rtl/ntcpa_pkg.sv
// ----------------------------------------------------------------------------
// ntcpa_pkg
// Shared constants, status codes and the NTC resistance ROM for the
// thermistor and pressure conversion core.
// ----------------------------------------------------------------------------
package ntcpa_pkg;

  // Resistance numerator, 128000000 = 27 bits
  localparam int unsigned NUM_W = 27;
  localparam logic [NUM_W-1:0] RES_NUMERATOR = 27'd128000000;
  localparam int unsigned CNT_W = 5;

  localparam int unsigned ROM_W     = 15;
  localparam int unsigned ROM_IDX_W = 8;

  localparam logic [13:0] RES_REF_OHMS = 14'd10000;
  localparam logic [6:0]  PRES_MAX     = 7'd100;

  // range_status codes
  localparam logic [1:0] ST_IN_RANGE   = 2'd0;
  localparam logic [1:0] ST_CLAMP_LOW  = 2'd1;
  localparam logic [1:0] ST_CLAMP_HIGH = 2'd2;

  // Thermistor resistance in ohms at 0..100 C; unused entries read as zero.
  function automatic logic [ROM_W-1:0] ntc_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [ROM_W-1:0] v;
    case (idx)
      8'd0: v = 15'd32754;   8'd1: v = 15'd31124;   8'd2: v = 15'd29584;
      8'd3: v = 15'd28130;   8'd4: v = 15'd26755;   8'd5: v = 15'd25456;
      8'd6: v = 15'd24227;   8'd7: v = 15'd23065;   8'd8: v = 15'd21965;
      8'd9: v = 15'd20923;   8'd10: v = 15'd19938;  8'd11: v = 15'd19004;
      8'd12: v = 15'd18119;  8'd13: v = 15'd17280;  8'd14: v = 15'd16485;
      8'd15: v = 15'd15731;  8'd16: v = 15'd15016;  8'd17: v = 15'd14337;
      8'd18: v = 15'd13693;  8'd19: v = 15'd13081;  8'd20: v = 15'd12500;
      8'd21: v = 15'd11948;  8'd22: v = 15'd11423;  8'd23: v = 15'd10925;
      8'd24: v = 15'd10451;  8'd25: v = 15'd10000;  8'd26: v = 15'd9570;
      8'd27: v = 15'd9162;   8'd28: v = 15'd8773;   8'd29: v = 15'd8403;
      8'd30: v = 15'd8051;   8'd31: v = 15'd7715;   8'd32: v = 15'd7395;
      8'd33: v = 15'd7090;   8'd34: v = 15'd6799;   8'd35: v = 15'd6522;
      8'd36: v = 15'd6257;   8'd37: v = 15'd6005;   8'd38: v = 15'd5764;
      8'd39: v = 15'd5534;   8'd40: v = 15'd5314;   8'd41: v = 15'd5104;
      8'd42: v = 15'd4904;   8'd43: v = 15'd4713;   8'd44: v = 15'd4530;
      8'd45: v = 15'd4355;   8'd46: v = 15'd4187;   8'd47: v = 15'd4027;
      8'd48: v = 15'd3874;   8'd49: v = 15'd3728;   8'd50: v = 15'd3588;
      8'd51: v = 15'd3454;   8'd52: v = 15'd3325;   8'd53: v = 15'd3202;
      8'd54: v = 15'd3084;   8'd55: v = 15'd2971;   8'd56: v = 15'd2863;
      8'd57: v = 15'd2759;   8'd58: v = 15'd2660;   8'd59: v = 15'd2564;
      8'd60: v = 15'd2473;   8'd61: v = 15'd2385;   8'd62: v = 15'd2301;
      8'd63: v = 15'd2220;   8'd64: v = 15'd2143;   8'd65: v = 15'd2068;
      8'd66: v = 15'd1997;   8'd67: v = 15'd1928;   8'd68: v = 15'd1862;
      8'd69: v = 15'd1798;   8'd70: v = 15'd1738;   8'd71: v = 15'd1679;
      8'd72: v = 15'd1623;   8'd73: v = 15'd1568;   8'd74: v = 15'd1516;
      8'd75: v = 15'd1466;   8'd76: v = 15'd1418;   8'd77: v = 15'd1372;
      8'd78: v = 15'd1327;   8'd79: v = 15'd1284;   8'd80: v = 15'd1243;
      8'd81: v = 15'd1203;   8'd82: v = 15'd1164;   8'd83: v = 15'd1127;
      8'd84: v = 15'd1092;   8'd85: v = 15'd1058;   8'd86: v = 15'd1024;
      8'd87: v = 15'd993;    8'd88: v = 15'd962;    8'd89: v = 15'd932;
      8'd90: v = 15'd904;    8'd91: v = 15'd876;    8'd92: v = 15'd849;
      8'd93: v = 15'd824;    8'd94: v = 15'd799;    8'd95: v = 15'd775;
      8'd96: v = 15'd752;    8'd97: v = 15'd730;    8'd98: v = 15'd708;
      8'd99: v = 15'd687;    8'd100: v = 15'd667;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ntc_and_pressure_adc_conversion_core.sv
// ----------------------------------------------------------------------------
// ntc_and_pressure_adc_conversion_core
// Converts a thermistor ADC sample to whole degrees C through a resistance
// ROM, and a pressure ADC sample to percent of full scale.
// ----------------------------------------------------------------------------
// Sequence: accept, then 27 divider steps, subtract, classify, up to
//   ceil(log2(TABLE_ENTRIES-1)) search steps (7 at 101 entries) plus a final
//   one, finish. Clamped readings leave after subtract or classify, and a
//   zero temperature sample goes straight from accept to finish.
// Flow: one item at a time; in_ready returns in the same cycle as out_valid,
//   and a finished result waits in the finish state while the previous
//   result is still waiting for out_ready.
// Reset: synchronous, active low; returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module ntc_and_pressure_adc_conversion_core #(
  parameter int unsigned TABLE_ENTRIES = 101,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_temp_sample,
  input  logic [SAMPLE_BITS-1:0] in_pressure_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             out_temperature_c,
  output logic [1:0]             out_range_status,
  output logic [6:0]             out_pressure_percent
);
  import ntcpa_pkg::*;

  // divisor 3*sample, pressure sum 3*sample+64
  localparam int unsigned DV_W  = SAMPLE_BITS + 2;
  localparam int unsigned PQ_W  = SAMPLE_BITS - 5;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [6:0]       LAST_DEG = 7'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SUB, S_CLASS, S_SEARCH, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [DV_W-1:0]  dv_r, dv_nxt;        // divisor
  logic [DV_W-1:0]  rem_r, rem_nxt;      // partial remainder
  logic [NUM_W-1:0] qd_r, qd_nxt;        // dividend in, quotient out
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] res_r, res_nxt;      // resistance above 10k reference
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [6:0]       deg_r, deg_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [6:0]       pres_r, pres_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_temp_r, out_temp_nxt;
  logic [1:0]       out_stat_r, out_stat_nxt;
  logic [6:0]       out_pres_r, out_pres_nxt;

  logic [DV_W:0]    trial;
  logic [NUM_W:0]   diff;
  logic [DV_W-1:0]  pres_sum;
  logic [PQ_W-1:0]  pres_q;
  logic [IDX_W-1:0] span, mid;
  logic [NUM_W-1:0] rom_first, rom_last, rom_mid;

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_temperature_c    = out_temp_r;
  assign out_range_status     = out_stat_r;
  assign out_pressure_percent = out_pres_r;

  // Pressure: floor((3*s + 64) / 128), saturated at full scale
  assign pres_sum = ({2'b00, in_pressure_sample} << 1) + {2'b00, in_pressure_sample}
                    + DV_W'(64);
  assign pres_q   = pres_sum[DV_W-1:7];

  // restoring division step: bring down the next dividend bit
  assign trial = {rem_r, qd_r[NUM_W-1]};
  assign diff  = {1'b0, qd_r} - (NUM_W+1)'(RES_REF_OHMS);

  assign span      = hi_r - lo_r;
  assign mid       = lo_r + (span >> 1);
  assign rom_first = NUM_W'(ntc_rom(ROM_IDX_W'(0)));
  assign rom_last  = NUM_W'(ntc_rom(ROM_IDX_W'(TABLE_ENTRIES - 1)));
  assign rom_mid   = NUM_W'(ntc_rom(ROM_IDX_W'(mid)));

  always_comb begin
    state_nxt     = state_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    deg_nxt       = deg_r;
    stat_nxt      = stat_r;
    pres_nxt      = pres_r;
    out_temp_nxt  = out_temp_r;
    out_stat_nxt  = out_stat_r;
    out_pres_nxt  = out_pres_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dv_nxt  = ({2'b00, in_temp_sample} << 1) + {2'b00, in_temp_sample};
          rem_nxt = '0;
          qd_nxt  = RES_NUMERATOR;
          cnt_nxt = CNT_W'(NUM_W - 1);
          if (32'(pres_q) > 32'(PRES_MAX)) begin
            pres_nxt = PRES_MAX;
          end else begin
            pres_nxt = 7'(pres_q);
          end
          if (in_temp_sample == '0) begin
            // no divider current: treat as open sensor, clamp low
            deg_nxt   = 7'd0;
            stat_nxt  = ST_CLAMP_LOW;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dv_r}) begin
          rem_nxt = DV_W'(trial - {1'b0, dv_r});
          qd_nxt  = {qd_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DV_W-1:0];
          qd_nxt  = {qd_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        // quotient below the series reference: clamp hot
        if (diff[NUM_W]) begin
          deg_nxt   = LAST_DEG;
          stat_nxt  = ST_CLAMP_HIGH;
          state_nxt = S_FIN;
        end else begin
          res_nxt   = diff[NUM_W-1:0];
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (res_r > rom_first) begin
          deg_nxt   = 7'd0;
          stat_nxt  = ST_CLAMP_LOW;
          state_nxt = S_FIN;
        end else if (res_r == rom_first) begin
          deg_nxt   = 7'd0;
          stat_nxt  = ST_IN_RANGE;
          state_nxt = S_FIN;
        end else if (res_r < rom_last) begin
          deg_nxt   = LAST_DEG;
          stat_nxt  = ST_CLAMP_HIGH;
          state_nxt = S_FIN;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = LAST_IDX;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // invariant: rom[lo] > R >= rom[hi]; table falls monotonically
        if (span > IDX_W'(1)) begin
          if (rom_mid <= res_r) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid;
          end
        end else begin
          deg_nxt   = 7'(hi_r);
          stat_nxt  = ST_IN_RANGE;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_temp_nxt  = deg_r;
          out_stat_nxt  = stat_r;
          out_pres_nxt  = pres_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
      rem_r       <= rem_nxt;
      qd_r        <= qd_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      deg_r       <= deg_nxt;
      stat_r      <= stat_nxt;
      pres_r      <= pres_nxt;
      out_temp_r  <= out_temp_nxt;
      out_stat_r  <= out_stat_nxt;
      out_pres_r  <= out_pres_nxt;
    end
  end

endmodule

### bench/ntc_and_pressure_adc_conversion_core_test.sv
// ----------------------------------------------------------------------------
// ntc_and_pressure_adc_conversion_core_test
// Self-checking bench for the thermistor and pressure conversion core. Sample
// pairs go in over a valid/ready channel with random idle bursts. Each result
// is checked against an in-bench conversion of the same pair.
// ----------------------------------------------------------------------------
module ntc_and_pressure_adc_conversion_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntcpa_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 880;
  localparam int unsigned TAIL_ITEMS   = 100;   // no idling on either side
  localparam int unsigned DRAIN_CYCLES = 64;    // longer than the worst-case latency of the core
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One input item; drain_first holds it back until all results are in.
  typedef struct packed {
    logic [11:0] temp;
    logic [11:0] pres;
    logic        drain_first;
  } sample_pair_t;

  // One result item.
  typedef struct packed {
    logic [6:0] deg;
    logic [1:0] status;
    logic [6:0] pct;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_temp_sample = '0;
  logic [11:0] in_pressure_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_temperature_c;
  logic [1:0]  out_range_status;
  logic [6:0]  out_pressure_percent;

  sample_pair_t pending_pairs[$];
  reading_t     readings_due[$];

  int unsigned issued_count = 0;   // items put on the input port
  int unsigned accept_count = 0;   // items taken by the core
  int unsigned total_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Thermistor resistance in ohms at 0..100 C, falling.
  int unsigned ohms_at_degree [0:100] = '{
    32754, 31124, 29584, 28130, 26755, 25456, 24227, 23065, 21965, 20923,
    19938, 19004, 18119, 17280, 16485, 15731, 15016, 14337, 13693, 13081,
    12500, 11948, 11423, 10925, 10451, 10000,  9570,  9162,  8773,  8403,
     8051,  7715,  7395,  7090,  6799,  6522,  6257,  6005,  5764,  5534,
     5314,  5104,  4904,  4713,  4530,  4355,  4187,  4027,  3874,  3728,
     3588,  3454,  3325,  3202,  3084,  2971,  2863,  2759,  2660,  2564,
     2473,  2385,  2301,  2220,  2143,  2068,  1997,  1928,  1862,  1798,
     1738,  1679,  1623,  1568,  1516,  1466,  1418,  1372,  1327,  1284,
     1243,  1203,  1164,  1127,  1092,  1058,  1024,   993,   962,   932,
      904,   876,   849,   824,   799,   775,   752,   730,   708,   687,
      667
  };

  ntc_and_pressure_adc_conversion_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_temp_sample       (in_temp_sample),
    .in_pressure_sample   (in_pressure_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_temperature_c    (out_temperature_c),
    .out_range_status     (out_range_status),
    .out_pressure_percent (out_pressure_percent)
  );

  always #1 clk = ~clk;

  // Expected reading for one sample pair.
  // Temperature: R = 128e6 / (3 * sample) - 10k, then the first degree whose
  // table entry is at or below R. Pressure: (3 * sample + 64) / 128, max 100.
  function automatic reading_t convert_pair(logic [11:0] temp, logic [11:0] pres);
    reading_t    rd;
    int unsigned ts;
    int unsigned quot;
    int unsigned ohms;
    int unsigned pct;
    rd = '0;
    ts = temp;
    if (ts == 0) begin
      // no divider reading at all: treat as cold clamp
      rd.deg = 7'd0;
      rd.status = ST_CLAMP_LOW;
    end else begin
      quot = 32'd128000000 / (32'd3 * ts);
      if (quot < 32'd10000) begin
        rd.deg = 7'd100;
        rd.status = ST_CLAMP_HIGH;
      end else begin
        ohms = quot - 32'd10000;
        if (ohms > ohms_at_degree[0]) begin
          rd.deg = 7'd0;
          rd.status = ST_CLAMP_LOW;
        end else if (ohms == ohms_at_degree[0]) begin
          rd.deg = 7'd0;
          rd.status = ST_IN_RANGE;
        end else if (ohms < ohms_at_degree[100]) begin
          rd.deg = 7'd100;
          rd.status = ST_CLAMP_HIGH;
        end else begin
          rd.status = ST_IN_RANGE;
          rd.deg = 7'd100;
          // walk down so the lowest matching degree wins
          for (int i = 100; i >= 1; i--) begin
            if (ohms_at_degree[i] <= ohms) rd.deg = i[6:0];
          end
        end
      end
    end
    pct = (32'd3 * pres + 32'd64) / 32'd128;
    if (pct > 100) pct = 100;
    rd.pct = pct[6:0];
    return rd;
  endfunction

  task automatic add_pair(logic [11:0] temp, logic [11:0] pres, logic drain_first);
    sample_pair_t sp;
    sp.temp = temp;
    sp.pres = pres;
    sp.drain_first = drain_first;
    pending_pairs.push_back(sp);
  endtask

  // Sender: runs on the falling edge and pulls from pending_pairs.
  // accept_count == issued_count means the item on the port was taken at the
  // last rising edge.
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accept_count == issued_count) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
        // start a random idle burst that includes this cycle
        send_gap = $urandom_range(1, 16) - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0 && pending_pairs[0].drain_first &&
                   readings_due.size() > 0) begin
        // hold off until every outstanding result is back
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        sample_pair_t sp;
        sp = pending_pairs.pop_front();
        in_temp_sample <= sp.temp;
        in_pressure_sample <= sp.pres;
        issued_count++;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stall bursts, none in the tail.
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (pending_pairs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: log accepted inputs, then check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      readings_due.push_back(convert_pair(in_temp_sample, in_pressure_sample));
      accept_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result deg=%0d status=%0d pct=%0d", $time,
                 out_temperature_c, out_range_status, out_pressure_percent);
        mismatch_count++;
      end else begin
        reading_t rd;
        rd = readings_due.pop_front();
        if (out_temperature_c !== rd.deg) begin
          $display("%0t: temperature_c expected %0d actual %0d", $time, rd.deg,
                   out_temperature_c);
          mismatch_count++;
        end
        if (out_range_status !== rd.status) begin
          $display("%0t: range_status expected %0d actual %0d", $time, rd.status,
                   out_range_status);
          mismatch_count++;
        end
        if (out_pressure_percent !== rd.pct) begin
          $display("%0t: pressure_percent expected %0d actual %0d", $time, rd.pct,
                   out_pressure_percent);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Directed: zero sample, cold clamp region (R above table top, s <= 997),
    // first in-range codes, mid scale, hot clamp edge (s >= 4000), full scale,
    // alternating bit patterns, and pressure rounding edges.
    add_pair(12'd0,    12'd0,    1'b0);
    add_pair(12'd1,    12'd4095, 1'b0);
    add_pair(12'd500,  12'd21,   1'b0);
    add_pair(12'd997,  12'd22,   1'b0);
    add_pair(12'd998,  12'd64,   1'b0);   // pressure exactly on a half step
    add_pair(12'd999,  12'd63,   1'b0);
    add_pair(12'd1000, 12'd65,   1'b0);
    add_pair(12'd1250, 12'd2048, 1'b0);
    add_pair(12'd2048, 12'd2047, 1'b0);
    add_pair(12'd2730, 12'd1365, 1'b0);   // 0xAAA / 0x555
    add_pair(12'd1365, 12'd2730, 1'b0);
    add_pair(12'd3000, 12'd3000, 1'b0);
    add_pair(12'd3500, 12'd4000, 1'b0);
    add_pair(12'd3998, 12'd4094, 1'b0);
    add_pair(12'd3999, 12'd1,    1'b0);
    add_pair(12'd4000, 12'd0,    1'b0);
    add_pair(12'd4001, 12'd4095, 1'b0);
    add_pair(12'd4095, 12'd4095, 1'b0);
    add_pair(12'd0,    12'd4095, 1'b0);
    add_pair(12'd4095, 12'd0,    1'b0);
    add_pair(12'd1,    12'd0,    1'b1);   // wait for a fully drained core

    // Random: mostly uniform, with extra weight on the clamp edges.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      logic [11:0] temp;
      logic [11:0] pres;
      case ($urandom_range(0, 9))
        0:       temp = $urandom_range(0, 3) == 0 ? 12'd0 : 12'($urandom_range(990, 1010));
        1:       temp = 12'($urandom_range(3980, 4095));
        default: temp = 12'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 9) == 0)
        pres = $urandom_range(0, 1) ? 12'd4095 : 12'($urandom_range(0, 64));
      else
        pres = 12'($urandom_range(0, 4095));
      add_pair(temp, pres, $urandom_range(0, 99) == 0);
    end
    total_items = pending_pairs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accept_count < total_items) @(posedge clk);
    while (readings_due.size() > 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
